// ===== hdl/psdd_pkg.sv =====
// Shared types, register indexes and constants for the steering PID block.
package psdd_pkg;

    localparam int unsigned ErrW  = 16;
    localparam int unsigned VelW  = 15;
    localparam int unsigned GainW = 16;
    localparam int unsigned LimW  = 8;
    localparam int unsigned DutyW = 7;
    localparam int unsigned SumW  = 10;
    localparam int unsigned IdxW  = 3;

    // Integral clamp: +/-1.0 in Q8.8
    localparam logic signed [SumW-1:0] SUM_MAX = 10'sd256;
    localparam logic signed [SumW-1:0] SUM_MIN = -10'sd256;

    localparam logic [DutyW-1:0] DUTY_MAX = 7'd100;

    localparam logic signed [LimW-1:0] OUT_MIN_RST = -8'sd100;
    localparam logic signed [LimW-1:0] OUT_MAX_RST = 8'sd100;

    // Register map
    localparam logic [IdxW-1:0] REG_GAIN_P  = 3'd0;
    localparam logic [IdxW-1:0] REG_GAIN_I  = 3'd1;
    localparam logic [IdxW-1:0] REG_GAIN_D  = 3'd2;
    localparam logic [IdxW-1:0] REG_OUT_MIN = 3'd3;
    localparam logic [IdxW-1:0] REG_OUT_MAX = 3'd4;

    typedef struct packed {
        logic signed [GainW-1:0] gain_p;
        logic signed [GainW-1:0] gain_i;
        logic signed [GainW-1:0] gain_d;
        logic signed [LimW-1:0]  out_min;
        logic signed [LimW-1:0]  out_max;
    } cfg_t;

    typedef struct packed {
        logic [DutyW-1:0]       left_duty;
        logic [DutyW-1:0]       right_duty;
        logic signed [LimW-1:0] correction;
    } result_t;

endpackage

// ===== hdl/pid_steering_differential_drive.sv =====
// Top level: steering PID with differential drive mixing, config registers, beat handshake.
// Steering PID controller with differential drive mixing. Each input beat carries a
// signed Q8.8 steering error and an unsigned Q7.8 base velocity; each output beat
// gives the left and right forward duties (0..100) and the clamped integer correction.
// Throughput is one beat per clock while the output is not stalled: the integral and
// previous-error state are updated in the single compute stage, so back-to-back beats
// see each other's state with no bubble. out_valid rises once the beat has passed the
// input register and then the result register, which waits while the result register
// is full and stalled. The output register decouples the sides, so a new beat is taken
// while a finished result waits, as long as the compute stage can drain.
// Configuration registers (gain_p, gain_i, gain_d, out_min, out_max at indexes 0..4)
// are written through the cfg channel, which is always ready; unknown indexes are
// ignored. Write them only while no beat is in flight.
module pid_steering_differential_drive
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [psdd_pkg::IdxW-1:0]            cfg_index,
    input  logic [psdd_pkg::GainW-1:0]           cfg_data,
    // input channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [psdd_pkg::ErrW-1:0]     error_in,
    input  logic [psdd_pkg::VelW-1:0]            velocity,
    // output channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [psdd_pkg::DutyW-1:0]           left_duty,
    output logic [psdd_pkg::DutyW-1:0]           right_duty,
    output logic signed [psdd_pkg::LimW-1:0]     correction
);

    psdd_pkg::cfg_t cfg_reg;

    // input stage
    logic                                s1_valid_reg;
    logic signed [psdd_pkg::ErrW-1:0]    s1_err_reg;
    logic [psdd_pkg::VelW-1:0]           s1_vel_reg;

    // controller state
    logic signed [psdd_pkg::SumW-1:0]    error_sum_reg;
    logic signed [psdd_pkg::SumW-1:0]    error_sum_next;
    logic signed [psdd_pkg::ErrW-1:0]    last_error_reg;

    // result stage
    logic                                out_valid_reg;
    psdd_pkg::result_t                   out_reg;
    psdd_pkg::result_t                   result_next;

    logic out_free;
    logic s1_move;
    logic in_take;

    // Result register can load when empty or being drained this cycle.
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_move  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    assign cfg_ready = 1'b1;

    // Configuration register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p  <= '0;
            cfg_reg.gain_i  <= '0;
            cfg_reg.gain_d  <= '0;
            cfg_reg.out_min <= psdd_pkg::OUT_MIN_RST;
            cfg_reg.out_max <= psdd_pkg::OUT_MAX_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                psdd_pkg::REG_GAIN_P:  cfg_reg.gain_p  <= cfg_data;
                psdd_pkg::REG_GAIN_I:  cfg_reg.gain_i  <= cfg_data;
                psdd_pkg::REG_GAIN_D:  cfg_reg.gain_d  <= cfg_data;
                psdd_pkg::REG_OUT_MIN: cfg_reg.out_min <= cfg_data[psdd_pkg::LimW-1:0];
                psdd_pkg::REG_OUT_MAX: cfg_reg.out_max <= cfg_data[psdd_pkg::LimW-1:0];
                default: ;
            endcase
        end
    end

    // Datapath: PID terms, rounding, clamp, mixing
    psdd_core u_core
    (
        .cfg            (cfg_reg),
        .err            (s1_err_reg),
        .vel            (s1_vel_reg),
        .error_sum      (error_sum_reg),
        .last_error     (last_error_reg),
        .error_sum_next (error_sum_next),
        .result         (result_next)
    );

    // Control and controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            error_sum_reg  <= '0;
            last_error_reg <= '0;
        end
        else
        begin
            if (in_take)
                s1_valid_reg <= 1'b1;
            else if (s1_move)
                s1_valid_reg <= 1'b0;

            if (s1_move)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            // state advances exactly once per beat, as it leaves the compute stage
            if (s1_move)
            begin
                error_sum_reg  <= error_sum_next;
                last_error_reg <= s1_err_reg;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_err_reg <= error_in;
            s1_vel_reg <= velocity;
        end
        if (s1_move)
            out_reg <= result_next;
    end

    assign out_valid  = out_valid_reg;
    assign left_duty  = out_reg.left_duty;
    assign right_duty = out_reg.right_duty;
    assign correction = out_reg.correction;

endmodule

// ===== hdl/psdd_core.sv =====
// Combinational PID term, rounding, clamping and differential mixing.
module psdd_core
(
    input  psdd_pkg::cfg_t                          cfg,
    input  logic signed [psdd_pkg::ErrW-1:0]        err,
    input  logic [psdd_pkg::VelW-1:0]               vel,
    input  logic signed [psdd_pkg::SumW-1:0]        error_sum,
    input  logic signed [psdd_pkg::ErrW-1:0]        last_error,
    output logic signed [psdd_pkg::SumW-1:0]        error_sum_next,
    output psdd_pkg::result_t                       result
);

    logic signed [psdd_pkg::GainW-1:0] kp;
    logic signed [psdd_pkg::GainW-1:0] ki;
    logic signed [psdd_pkg::GainW-1:0] kd;
    logic signed [psdd_pkg::LimW-1:0]  lim_lo;
    logic signed [psdd_pkg::LimW-1:0]  lim_hi;

    logic signed [16:0] integ_raw;
    logic signed [16:0] diff;
    logic signed [31:0] p_term;
    logic signed [25:0] i_term;
    logic signed [32:0] d_term;
    logic signed [33:0] pid_sum;
    logic signed [34:0] pid_rnd;
    logic signed [18:0] c_wide;
    logic signed [18:0] c_clamp;
    logic signed [psdd_pkg::LimW-1:0]  corr;
    logic [psdd_pkg::DutyW-1:0] vint;
    logic signed [8:0] l_sum;
    logic signed [8:0] r_sum;

    always_comb
    begin
        kp     = cfg.gain_p;
        ki     = cfg.gain_i;
        kd     = cfg.gain_d;
        lim_lo = cfg.out_min;
        lim_hi = cfg.out_max;

        // integral, clamped to +/-1.0
        integ_raw = 17'(error_sum) + 17'(err);
        if (integ_raw > 17'(psdd_pkg::SUM_MAX))
            error_sum_next = psdd_pkg::SUM_MAX;
        else if (integ_raw < 17'(psdd_pkg::SUM_MIN))
            error_sum_next = psdd_pkg::SUM_MIN;
        else
            error_sum_next = integ_raw[psdd_pkg::SumW-1:0];

        diff   = 17'(err) - 17'(last_error);
        p_term = kp * err;
        i_term = 26'(ki) * 26'(error_sum_next);
        d_term = 33'(kd) * diff;

        pid_sum = 34'(p_term) + 34'(i_term) + 34'(d_term);

        // round half away from zero: bias 0.5 up, or just under it when negative
        pid_rnd = 35'(pid_sum) + (pid_sum[33] ? 35'sd32767 : 35'sd32768);
        c_wide  = pid_rnd[34:16];

        // upper bound tested first; with crossed bounds, values above out_max give out_max, others out_min
        if (c_wide > 19'(lim_hi))
            c_clamp = 19'(lim_hi);
        else if (c_wide < 19'(lim_lo))
            c_clamp = 19'(lim_lo);
        else
            c_clamp = c_wide;
        corr = c_clamp[psdd_pkg::LimW-1:0];

        vint  = vel[psdd_pkg::VelW-1:8];
        l_sum = $signed({2'b00, vint}) + 9'(corr);
        r_sum = $signed({2'b00, vint}) - 9'(corr);

        if (l_sum[8])
            result.left_duty = '0;
        else if (l_sum > $signed({2'b00, psdd_pkg::DUTY_MAX}))
            result.left_duty = psdd_pkg::DUTY_MAX;
        else
            result.left_duty = l_sum[psdd_pkg::DutyW-1:0];

        if (r_sum[8])
            result.right_duty = '0;
        else if (r_sum > $signed({2'b00, psdd_pkg::DUTY_MAX}))
            result.right_duty = psdd_pkg::DUTY_MAX;
        else
            result.right_duty = r_sum[psdd_pkg::DutyW-1:0];

        result.correction = corr;
    end

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the steering PID block with differential drive mixing.
module testbench;

    localparam int unsigned IdxW  = psdd_pkg::IdxW;
    localparam int unsigned ErrW  = psdd_pkg::ErrW;
    localparam int unsigned VelW  = psdd_pkg::VelW;
    localparam int unsigned GainW = psdd_pkg::GainW;
    localparam int unsigned LimW  = psdd_pkg::LimW;
    localparam int unsigned DutyW = psdd_pkg::DutyW;

    // Idle wait after the last result has been taken, to let the block settle.
    localparam int DRAIN_CYCLES    = 4;
    localparam int PHASES          = 10;
    localparam int BEATS_PER_PHASE = 110;
    // Pressure phase runs with no idling, so the long hold fills the block.
    localparam int PRESSURE_PHASE  = 2;
    localparam int LONG_HOLD       = 64;
    localparam int GAP_MAX         = 17;

    // Register indexes the block does not decode; writes there must be ignored.
    localparam logic [IdxW-1:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [IdxW-1:0] REG_SPARE_LAST  = 3'd7;

    typedef enum logic {ROW_CFG, ROW_BEAT} row_kind_t;

    // One row of the directed plan: a register write or an input beat. Where
    // typed is set, want is the result read straight off the arithmetic;
    // otherwise the predictor supplies it.
    typedef struct packed {
        row_kind_t               kind;
        logic [IdxW-1:0]         idx;
        logic [GainW-1:0]        data;
        logic signed [ErrW-1:0]  err;
        logic [VelW-1:0]         vel;
        logic                    typed;
        psdd_pkg::result_t       want;
    } step_row_t;

    localparam int PLAN_LEN = 40;
    localparam step_row_t PLAN [PLAN_LEN] = '{
        // After reset: all gains zero, so no correction whatever the error.
        '{ROW_BEAT, '0, '0, 16'sd0,     15'd0,     1'b1, '{7'd0,   7'd0,   8'sd0}},
        '{ROW_BEAT, '0, '0, 16'sh7fff,  15'd25600, 1'b1, '{7'd100, 7'd100, 8'sd0}},
        // Velocity above 100.0 saturates both duties.
        '{ROW_BEAT, '0, '0, 16'sh8000,  15'h7fff,  1'b1, '{7'd100, 7'd100, 8'sd0}},
        '{ROW_BEAT, '0, '0, 16'sd0,     15'd12800, 1'b1, '{7'd50,  7'd50,  8'sd0}},
        // kp = 1.0: correction is the rounded error.
        '{ROW_CFG, psdd_pkg::REG_GAIN_P, 16'd256, '0, '0, 1'b0, '0},
        '{ROW_BEAT, '0, '0, 16'sd2560,  15'd12800, 1'b1, '{7'd60,  7'd40,  8'sd10}},
        // Ties round away from zero, both signs; velocity fraction is dropped.
        '{ROW_BEAT, '0, '0, 16'sd128,   15'd13055, 1'b1, '{7'd51,  7'd49,  8'sd1}},
        '{ROW_BEAT, '0, '0, -16'sd128,  15'd12800, 1'b1, '{7'd49,  7'd51,  -8'sd1}},
        '{ROW_BEAT, '0, '0, 16'sd127,   15'd12800, 1'b1, '{7'd50,  7'd50,  8'sd0}},
        // Clamp at the reset bounds; negative drive floors at zero.
        '{ROW_BEAT, '0, '0, 16'sh7fff,  15'd0,     1'b1, '{7'd100, 7'd0,   8'sd100}},
        '{ROW_BEAT, '0, '0, 16'sh8000,  15'd25600, 1'b1, '{7'd0,   7'd100, -8'sd100}},
        // Crossed bounds: the upper test wins.
        '{ROW_CFG, psdd_pkg::REG_OUT_MIN, 16'd20,    '0, '0, 1'b0, '0},
        '{ROW_CFG, psdd_pkg::REG_OUT_MAX, 16'hffec,  '0, '0, 1'b0, '0},
        '{ROW_BEAT, '0, '0, 16'sd2560,  15'd12800, 1'b1, '{7'd30,  7'd70,  -8'sd20}},
        '{ROW_BEAT, '0, '0, -16'sd7680, 15'd12800, 1'b1, '{7'd70,  7'd30,  8'sd20}},
        // Widest bounds.
        '{ROW_CFG, psdd_pkg::REG_OUT_MIN, 16'h0080,  '0, '0, 1'b0, '0},
        '{ROW_CFG, psdd_pkg::REG_OUT_MAX, 16'h007f,  '0, '0, 1'b0, '0},
        '{ROW_BEAT, '0, '0, 16'sh7fff,  15'd12800, 1'b1, '{7'd100, 7'd0,   8'sd127}},
        '{ROW_BEAT, '0, '0, 16'sh8000,  15'd12800, 1'b1, '{7'd0,   7'd100, 8'sh80}},
        // Integral and derivative at the gain extremes; integral hits its clamp.
        '{ROW_CFG, psdd_pkg::REG_GAIN_P, 16'h0000,   '0, '0, 1'b0, '0},
        '{ROW_CFG, psdd_pkg::REG_GAIN_I, 16'h7fff,   '0, '0, 1'b0, '0},
        '{ROW_CFG, psdd_pkg::REG_GAIN_D, 16'h8000,   '0, '0, 1'b0, '0},
        '{ROW_BEAT, '0, '0, 16'sd200,   15'd12800, 1'b0, '0},
        '{ROW_BEAT, '0, '0, 16'sd200,   15'd6400,  1'b0, '0},
        '{ROW_BEAT, '0, '0, 16'sd200,   15'd19200, 1'b0, '0},
        '{ROW_BEAT, '0, '0, 16'sh8000,  15'd25600, 1'b0, '0},
        '{ROW_BEAT, '0, '0, 16'sh7fff,  15'd0,     1'b0, '0},
        '{ROW_BEAT, '0, '0, 16'sd0,     15'd12800, 1'b0, '0},
        '{ROW_CFG, psdd_pkg::REG_GAIN_P, 16'h8000,   '0, '0, 1'b0, '0},
        '{ROW_CFG, psdd_pkg::REG_GAIN_I, 16'h8000,   '0, '0, 1'b0, '0},
        '{ROW_CFG, psdd_pkg::REG_GAIN_D, 16'h7fff,   '0, '0, 1'b0, '0},
        '{ROW_CFG, psdd_pkg::REG_OUT_MIN, 16'hff9c,  '0, '0, 1'b0, '0},
        '{ROW_CFG, psdd_pkg::REG_OUT_MAX, 16'h0064,  '0, '0, 1'b0, '0},
        '{ROW_BEAT, '0, '0, 16'sd1,     15'd100,   1'b0, '0},
        '{ROW_BEAT, '0, '0, -16'sd1,    15'd25600, 1'b0, '0},
        '{ROW_BEAT, '0, '0, 16'sh7fff,  15'd12800, 1'b0, '0},
        '{ROW_BEAT, '0, '0, 16'sh8000,  15'd12800, 1'b0, '0},
        // Writes to undecoded indexes change nothing.
        '{ROW_CFG, REG_SPARE_FIRST, 16'hffff, '0, '0, 1'b0, '0},
        '{ROW_CFG, REG_SPARE_LAST,  16'h0000, '0, '0, 1'b0, '0},
        '{ROW_BEAT, '0, '0, 16'sd64,    15'd12800, 1'b0, '0}
    };

    // DUT connections; every input is known from time zero.
    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [IdxW-1:0]         cfg_index = '0;
    logic [GainW-1:0]        cfg_data  = '0;
    logic                    in_valid  = 1'b0;
    logic                    in_stall;
    logic signed [ErrW-1:0]  error_in  = '0;
    logic [VelW-1:0]         velocity  = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [DutyW-1:0]        left_duty;
    logic [DutyW-1:0]        right_duty;
    logic signed [LimW-1:0]  correction;

    // Predictor copy of the registers and the controller state.
    logic signed [GainW-1:0] kp       = '0;
    logic signed [GainW-1:0] ki       = '0;
    logic signed [GainW-1:0] kd       = '0;
    logic signed [LimW-1:0]  corr_lo  = psdd_pkg::OUT_MIN_RST;
    logic signed [LimW-1:0]  corr_hi  = psdd_pkg::OUT_MAX_RST;
    int                      err_integral = 0;
    logic signed [ErrW-1:0]  err_prev     = '0;

    psdd_pkg::result_t duty_q [$];   // predicted results, oldest first

    int  beats_sent   = 0;
    int  results_seen = 0;
    int  reg_writes   = 0;
    int  mismatches   = 0;
    bit  no_idle      = 1'b0;  // both sides run flat out
    bit  hold_req     = 1'b0;  // ask the result side for one long hold-off

    always #5 clk = ~clk;

    pid_steering_differential_drive uut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .error_in   (error_in),
        .velocity   (velocity),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .left_duty  (left_duty),
        .right_duty (right_duty),
        .correction (correction)
    );

    // PID step plus mixing; advances the predictor state.
    function automatic psdd_pkg::result_t pid_mix(input logic signed [ErrW-1:0] e,
                                                  input logic [VelW-1:0] v);
        longint            acc;
        longint            s;
        longint            c;
        longint            base;
        longint            l;
        longint            r;
        psdd_pkg::result_t res;
        acc = longint'(err_integral) + longint'(e);
        if (acc > longint'(psdd_pkg::SUM_MAX))
            acc = longint'(psdd_pkg::SUM_MAX);
        else if (acc < longint'(psdd_pkg::SUM_MIN))
            acc = longint'(psdd_pkg::SUM_MIN);
        s = longint'(kp) * longint'(e) + longint'(ki) * acc
            + longint'(kd) * (longint'(e) - longint'(err_prev));
        // Q16.16 to integer, ties away from zero
        if (s >= 0)
            c = (s + 32768) >>> 16;
        else
            c = -((-s + 32768) >>> 16);
        // upper bound tested first; with crossed bounds, values above out_max give out_max, others out_min
        if (c > longint'(corr_hi))
            c = longint'(corr_hi);
        else if (c < longint'(corr_lo))
            c = longint'(corr_lo);
        base = longint'(v >> 8);
        l = base + c;
        r = base - c;
        if (l < 0) l = 0;
        if (l > longint'(psdd_pkg::DUTY_MAX)) l = longint'(psdd_pkg::DUTY_MAX);
        if (r < 0) r = 0;
        if (r > longint'(psdd_pkg::DUTY_MAX)) r = longint'(psdd_pkg::DUTY_MAX);
        res.left_duty  = DutyW'(l);
        res.right_duty = DutyW'(r);
        res.correction = LimW'(c);
        err_integral = int'(acc);
        err_prev     = e;
        return res;
    endfunction

    function automatic logic signed [ErrW-1:0] rand_error();
        int r;
        case ($urandom_range(0, 9)) inside
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2, 3:    return ErrW'($urandom);
            default:
            begin
                r = $urandom_range(0, 3000) - 1500;
                return ErrW'(r);
            end
        endcase
    endfunction

    function automatic logic [VelW-1:0] rand_velocity();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 15'd25600;
            2:       return VelW'($urandom);
            default: return VelW'($urandom_range(0, 25600));
        endcase
    endfunction

    function automatic logic [GainW-1:0] rand_gain();
        int r;
        case ($urandom_range(0, 7)) inside
            0:       return 16'h7fff;
            1:       return 16'h8000;
            2:       return '0;
            3, 4:    return GainW'($urandom);
            default:
            begin
                r = $urandom_range(0, 1200) - 600;
                return GainW'(r);
            end
        endcase
    endfunction

    // One register write; the predictor takes it at the accepting edge.
    task automatic write_reg(input logic [IdxW-1:0] idx, input logic [GainW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            psdd_pkg::REG_GAIN_P:  kp = data;
            psdd_pkg::REG_GAIN_I:  ki = data;
            psdd_pkg::REG_GAIN_D:  kd = data;
            psdd_pkg::REG_OUT_MIN: corr_lo = data[LimW-1:0];
            psdd_pkg::REG_OUT_MAX: corr_hi = data[LimW-1:0];
            default: ;
        endcase
        reg_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one input beat after a random gap, or none while no_idle is set. Valid is left high on return so
    // a back-to-back beat follows without a bubble.
    task automatic send_beat(input logic signed [ErrW-1:0] e, input logic [VelW-1:0] v,
                             input logic typed, input psdd_pkg::result_t want);
        int                gap;
        psdd_pkg::result_t calc;
        gap = no_idle ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        error_in <= e;
        velocity <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        calc = pid_mix(e, v);
        duty_q.push_back(typed ? want : calc);
        beats_sent++;
    endtask

    // Quiesce: stop offering, wait for every result, then let the pipe settle.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (duty_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Result side: stall for a random count before each beat (none while no_idle is set), or for the long
    // hold when asked, then take the beat and compare it with the oldest
    // prediction.
    initial
    begin : result_sink
        int                hold;
        psdd_pkg::result_t want;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold     = LONG_HOLD;
                hold_req = 1'b0;
            end
            else if (no_idle)
                hold = 0;
            else
                hold = $urandom_range(0, GAP_MAX);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            results_seen++;
            if (duty_q.size() == 0)
            begin
                $error("result beat with nothing pending: left %0d right %0d correction %0d",
                       left_duty, right_duty, correction);
                mismatches++;
            end
            else
            begin
                want = duty_q.pop_front();
                if (left_duty !== want.left_duty)
                begin
                    $error("left_duty: expected %0d, got %0d", want.left_duty, left_duty);
                    mismatches++;
                end
                if (right_duty !== want.right_duty)
                begin
                    $error("right_duty: expected %0d, got %0d", want.right_duty, right_duty);
                    mismatches++;
                end
                if (correction !== want.correction)
                begin
                    $error("correction: expected %0d, got %0d", want.correction, correction);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog, well beyond the slowest legal run.
    initial
    begin : watchdog
        #2000000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin : stimulus
        logic [LimW-1:0] lo;
        logic [LimW-1:0] hi;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed plan: register rows only once the block has gone quiet.
        foreach (PLAN[i])
        begin
            if (PLAN[i].kind == ROW_CFG)
            begin
                drain_results();
                write_reg(PLAN[i].idx, PLAN[i].data);
            end
            else
                send_beat(PLAN[i].err, PLAN[i].vel, PLAN[i].typed, PLAN[i].want);
        end

        // Random phases, each under a fresh register setting.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain_results();
            if (ph == 0)
            begin
                // all gains at the positive extreme, widest bounds
                write_reg(psdd_pkg::REG_GAIN_P, 16'h7fff);
                write_reg(psdd_pkg::REG_GAIN_I, 16'h7fff);
                write_reg(psdd_pkg::REG_GAIN_D, 16'h7fff);
                write_reg(psdd_pkg::REG_OUT_MIN, 16'h0080);
                write_reg(psdd_pkg::REG_OUT_MAX, 16'h007f);
            end
            else if (ph == 1)
            begin
                // negative extreme, fully crossed bounds
                write_reg(psdd_pkg::REG_GAIN_P, 16'h8000);
                write_reg(psdd_pkg::REG_GAIN_I, 16'h8000);
                write_reg(psdd_pkg::REG_GAIN_D, 16'h8000);
                write_reg(psdd_pkg::REG_OUT_MIN, 16'hff7f);
                write_reg(psdd_pkg::REG_OUT_MAX, 16'h0080);
            end
            else
            begin
                write_reg(psdd_pkg::REG_GAIN_P, rand_gain());
                write_reg(psdd_pkg::REG_GAIN_I, rand_gain());
                write_reg(psdd_pkg::REG_GAIN_D, rand_gain());
                if ($urandom_range(0, 3) == 0)
                begin
                    lo = LimW'($urandom);
                    hi = LimW'($urandom);
                end
                else
                begin
                    lo = LimW'(-$urandom_range(0, 128));
                    hi = LimW'($urandom_range(0, 127));
                end
                // upper data bits are don't-care for the bound registers
                write_reg(psdd_pkg::REG_OUT_MIN, {8'($urandom), lo});
                write_reg(psdd_pkg::REG_OUT_MAX, {8'($urandom), hi});
                if ($urandom_range(0, 2) == 0)
                    write_reg(REG_SPARE_FIRST + IdxW'($urandom_range(0, 2)),
                              GainW'($urandom));
            end
            no_idle = (ph % 3 == PRESSURE_PHASE % 3);
            for (int k = 0; k < BEATS_PER_PHASE; k++)
            begin
                if (ph == PRESSURE_PHASE && k == 20)
                    hold_req = 1'b1;
                send_beat(rand_error(), rand_velocity(), 1'b0, '0);
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d input beats and %0d result beats across %0d register writes,",
                 beats_sent, results_seen, reg_writes);
        $display("including crossed and widest bounds, gain extremes and a long output hold.");
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
